>>> src/swc_pkg.sv
// Shared types, constants and the stop-word table for the stop word counter.
// No dependencies; every other file refers to it by scoped names.
package swc_pkg;

  localparam int WORD_MAX       = 4;
  localparam int LEN_BITS       = 3;
  localparam int LIST_LEN       = 25;
  localparam int RES_BITS       = 32;
  localparam int COUNT_BITS_DEF = 32;
  localparam int STOP_WORDS_DEF = 25;

  // delimiter bytes
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_line;
  } in_item_t;

  typedef struct packed {
    logic [RES_BITS-1:0] lines_seen;
    logic [RES_BITS-1:0] stop_hits;
    logic                final_res;
  } res_item_t;

  // current word: chars[k] holds character k, unused slots stay zero
  typedef struct packed {
    logic [WORD_MAX-1:0][7:0] chars;
    logic [LEN_BITS-1:0]      len;
    logic                     too_long;
  } word_t;

  typedef struct packed {
    logic [LEN_BITS-1:0]      len;
    logic [WORD_MAX-1:0][7:0] txt;
  } stop_entry_t;

  localparam stop_entry_t STOP_LIST [LIST_LEN] = '{
    '{len: 3'd1, txt: {8'h00, 8'h00, 8'h00, "a"}},
    '{len: 3'd2, txt: {8'h00, 8'h00, "n", "a"}},
    '{len: 3'd3, txt: {8'h00, "d", "n", "a"}},
    '{len: 3'd3, txt: {8'h00, "e", "r", "a"}},
    '{len: 3'd2, txt: {8'h00, 8'h00, "s", "a"}},
    '{len: 3'd2, txt: {8'h00, 8'h00, "t", "a"}},
    '{len: 3'd2, txt: {8'h00, 8'h00, "e", "b"}},
    '{len: 3'd2, txt: {8'h00, 8'h00, "y", "b"}},
    '{len: 3'd3, txt: {8'h00, "r", "o", "f"}},
    '{len: 3'd4, txt: {"m", "o", "r", "f"}},
    '{len: 3'd3, txt: {8'h00, "s", "a", "h"}},
    '{len: 3'd2, txt: {8'h00, 8'h00, "e", "h"}},
    '{len: 3'd2, txt: {8'h00, 8'h00, "n", "i"}},
    '{len: 3'd2, txt: {8'h00, 8'h00, "s", "i"}},
    '{len: 3'd2, txt: {8'h00, 8'h00, "t", "i"}},
    '{len: 3'd3, txt: {8'h00, "s", "t", "i"}},
    '{len: 3'd2, txt: {8'h00, 8'h00, "f", "o"}},
    '{len: 3'd2, txt: {8'h00, 8'h00, "n", "o"}},
    '{len: 3'd4, txt: {"t", "a", "h", "t"}},
    '{len: 3'd3, txt: {8'h00, "e", "h", "t"}},
    '{len: 3'd2, txt: {8'h00, 8'h00, "o", "t"}},
    '{len: 3'd3, txt: {8'h00, "s", "a", "w"}},
    '{len: 3'd4, txt: {"e", "r", "e", "w"}},
    '{len: 3'd4, txt: {"l", "l", "i", "w"}},
    '{len: 3'd4, txt: {"h", "t", "i", "w"}}
  };

  function automatic logic is_delim(input logic [7:0] c);
    return c == CH_SPACE || c == CH_COMMA || c == CH_SEMI || c == CH_COLON ||
           c == CH_QUERY || c == CH_BANG || c == CH_DOT || c == CH_NL;
  endfunction

endpackage

>>> src/swc_match.sv
// Parallel compare of the held word against the stop-word table.
// Depends on swc_pkg.
module swc_match #(
  parameter int STOP_WORDS = swc_pkg::STOP_WORDS_DEF
) (
  input  swc_pkg::word_t word,
  output logic           hit
);

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < swc_pkg::LIST_LEN; i++) begin
      if (i < STOP_WORDS && !word.too_long && word.len != '0 &&
          word.len == swc_pkg::STOP_LIST[i].len &&
          word.chars == swc_pkg::STOP_LIST[i].txt) begin
        hit = 1'b1;
      end
    end
  end

endmodule

>>> src/swc_wordbuf.sv
// Word buffer: up to four characters, a length and an overflow mark.
// Depends on swc_pkg.
module swc_wordbuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     ch,
  output swc_pkg::word_t word
);

  swc_pkg::word_t word_next;

  always_comb begin
    word_next = word;
    if (swc_pkg::is_delim(ch)) begin
      word_next = '0;
    end else if (word.len < swc_pkg::LEN_BITS'(swc_pkg::WORD_MAX)) begin
      word_next.chars[word.len[1:0]] = ch;
      word_next.len = word.len + swc_pkg::LEN_BITS'(1);
    end else begin
      word_next.too_long = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (step) begin
      word <= word_next;
    end
  end

endmodule

>>> src/swc_tally.sv
// Saturating line and hit counters, and the result they produce on a newline.
// Depends on swc_pkg.
module swc_tally #(
  parameter int COUNT_BITS = swc_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               is_nl,
  input  logic               last_line,
  input  logic               hit,
  output swc_pkg::res_item_t res
);

  logic [COUNT_BITS-1:0] line_count, hit_count;
  logic [COUNT_BITS-1:0] line_next, hit_next;
  logic [swc_pkg::RES_BITS-1:0] lines_out, hits_out;

  always_comb begin
    hit_next  = (hit && !(&hit_count)) ? hit_count + COUNT_BITS'(1) : hit_count;
    line_next = (&line_count) ? line_count : line_count + COUNT_BITS'(1);
  end

  // report clamps to the result width when wider, else is zero-extended
  if (COUNT_BITS > swc_pkg::RES_BITS) begin : g_clamp
    assign lines_out = (|line_next[COUNT_BITS-1:swc_pkg::RES_BITS]) ?
                       '1 : line_next[swc_pkg::RES_BITS-1:0];
    assign hits_out  = (|hit_next[COUNT_BITS-1:swc_pkg::RES_BITS]) ?
                       '1 : hit_next[swc_pkg::RES_BITS-1:0];
  end else begin : g_ext
    assign lines_out = swc_pkg::RES_BITS'(line_next);
    assign hits_out  = swc_pkg::RES_BITS'(hit_next);
  end

  assign res.lines_seen = lines_out;
  assign res.stop_hits  = hits_out;
  assign res.final_res  = last_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      hit_count  <= '0;
    end else if (step) begin
      if (is_nl && last_line) begin
        line_count <= '0;
        hit_count  <= '0;
      end else begin
        hit_count <= hit_next;
        if (is_nl) begin
          line_count <= line_next;
        end
      end
    end
  end

endmodule

>>> src/stop_word_counter.sv
// Top level of the stop word counter: input register, word buffer, matcher,
// counters and result register. Depends on swc_pkg, swc_wordbuf, swc_match, swc_tally.
//
// Usage
//   byte channel (byte_valid/byte_ready/byte_data): one text byte per beat,
//     with last_line set on the newline that closes the final line.
//   result channel (res_valid/res_ready/res_data): one beat per newline,
//     carrying the running line and stop-word counts; final_res marks the
//     total for the whole list, after which both counts restart at zero.
//   Bytes other than newline produce no result beat.
// Timing
//   A byte is captured into the input register at its accepting edge; a
//   newline loads the result register as it leaves the input register,
//   which it does only once the result register is free.
//   Throughput is one byte per cycle unless a newline waits on a stalled
//   result; the combinational word compare and counter update set that figure.
// Reset
//   rst (synchronous, active high) empties both registers and clears the
//   word buffer and both counters.
// Stall
//   While res_valid is held by a stalled receiver, non-newline bytes keep
//   flowing; a newline waits in the input register, and byte_ready drops
//   until the result register frees up.
module stop_word_counter #(
  parameter int COUNT_BITS = swc_pkg::COUNT_BITS_DEF,
  parameter int STOP_WORDS = swc_pkg::STOP_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  swc_pkg::in_item_t  byte_data,
  output logic               res_valid,
  input  logic               res_ready,
  output swc_pkg::res_item_t res_data
);

  // input register
  logic              s1_valid;
  swc_pkg::in_item_t s1_item;

  logic               s1_nl, s1_go, res_free, hit;
  swc_pkg::word_t     word;
  swc_pkg::res_item_t res_next;

  assign s1_nl      = s1_item.ch == swc_pkg::CH_NL;
  assign res_free   = !res_valid || res_ready;
  // a newline needs a free result slot; other bytes always go
  assign s1_go      = s1_valid && (!s1_nl || res_free);
  assign byte_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ready) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      s1_item <= byte_data;
    end
  end

  swc_wordbuf u_wordbuf (
    .clk  (clk),
    .rst  (rst),
    .step (s1_go),
    .ch   (s1_item.ch),
    .word (word)
  );

  // a match only counts when a delimiter arrives; the tally hit input gates on that
  swc_match #(
    .STOP_WORDS (STOP_WORDS)
  ) u_match (
    .word (word),
    .hit  (hit)
  );

  swc_tally #(
    .COUNT_BITS (COUNT_BITS)
  ) u_tally (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_go),
    .is_nl     (s1_nl),
    .last_line (s1_item.last_line),
    .hit       (hit && swc_pkg::is_delim(s1_item.ch)),
    .res       (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go && s1_nl) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_nl) begin
      res_data <= res_next;
    end
  end

endmodule

>>> src/swc_checker.sv
// Port-level checks for the stop word counter, bound to the top level.
// Depends on swc_pkg and stop_word_counter.
module swc_props (
  input logic               clk,
  input logic               rst,
  input logic               byte_ready,
  input logic               res_valid,
  input logic               res_ready,
  input swc_pkg::res_item_t res_data
);

  // a result held by the receiver does not change
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result beat changed while stalled");

  // every reported line count includes the line itself
  a_lines_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.lines_seen != '0)
    else $error("result with zero line count");

  // within one list the line count never goes backwards (equal only once saturated)
  a_monotone: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && !res_data.final_res) ##1 (res_valid && res_ready) |->
      res_data.lines_seen >= $past(res_data.lines_seen))
    else $error("line count went backwards");

  // the byte side only stalls behind a result the receiver is holding off
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> res_valid && !res_ready)
    else $error("byte_ready low without a stalled result");

  // the cycle after a reset cycle shows no result
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid straight after reset");

endmodule

bind stop_word_counter swc_props u_swc_props (
  .clk        (clk),
  .rst        (rst),
  .byte_ready (byte_ready),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res_data   (res_data)
);
